### rtl/bdlc_pkg.sv
// ----------------------------------------------------------------------------
// bdlc_pkg
// shared types, constants and helpers for the dump load controller
// ----------------------------------------------------------------------------
package bdlc_pkg;

   localparam int ADC_BITS = 12;
   localparam int SUM_W    = ADC_BITS + 8;
   localparam int CNT_W    = 9;
   localparam int SCALE_W  = 18;
   localparam int NUM_W    = SUM_W + SCALE_W;
   localparam int DEN_W    = ADC_BITS + CNT_W;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   localparam logic [SCALE_W-1:0] SCALE_3V3_Q = SCALE_W'(216269);
   localparam logic signed [31:0] SPLIT_2V6_Q = 32'sd170394;
   localparam logic signed [32:0] HARD_HIGH_Q = 33'sd3145728;
   localparam logic signed [32:0] HARD_LOW_Q  = 33'sd2673869;

   localparam logic [2:0] CSR_NUM_SAMPLES = 3'd0;
   localparam logic [2:0] CSR_LOW_SEG     = 3'd1;
   localparam logic [2:0] CSR_HIGH_SEG    = 3'd2;
   localparam logic [2:0] CSR_VOLT_CAL    = 3'd3;
   localparam logic [2:0] CSR_CURR_CAL    = 3'd4;
   localparam logic [2:0] CSR_DUMP_ON     = 3'd5;
   localparam logic [2:0] CSR_DUMP_OFF    = 3'd6;

   localparam logic [63:0] CAL_RESET      = 64'h0001_0000_0000_0000;
   localparam logic [7:0]  NUM_SAMPLES_RESET = 8'd16;
   localparam logic [22:0] DUMP_ON_RESET  = 23'd3014656;
   localparam logic [22:0] DUMP_OFF_RESET = 23'd2883584;

   localparam logic [1:0] MODE_AUTO_OFF = 2'd0;
   localparam logic [1:0] MODE_AUTO_ON  = 2'd1;
   localparam logic [1:0] MODE_MANUAL   = 2'd2;
   localparam logic [1:0] MODE_WARNING  = 2'd3;

   typedef struct packed {
      logic                cmd;
      logic [ADC_BITS-1:0] voltage_code;
      logic [ADC_BITS-1:0] current_code;
      logic                override_switch;
      logic                blink_on;
   } req_type;

   typedef struct packed {
      logic               gate;
      logic               green_drive;
      logic               red_led;
      logic [1:0]         mode;
      logic signed [31:0] voltage_out;
      logic signed [31:0] current_out;
   } rsp_type;

   // floor shift of a q16.16 product, add offset, saturate to 32 bits
   function automatic logic signed [31:0] cal_finish(logic signed [63:0] prod,
                                                     logic signed [31:0] offset);
      logic signed [48:0] sum;
      sum = {prod[63], prod[63:16]} + {{17{offset[31]}}, offset};
      if (sum > 49'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (sum < -49'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return sum[31:0];
      end
   endfunction

endpackage

### rtl/bdlc_divider.sv
// ----------------------------------------------------------------------------
// bdlc_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bdlc_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bdlc_pkg::NUM_W-1:0]    dividend,
   input  logic [bdlc_pkg::DEN_W-1:0]    divisor,
   output logic                          done,
   output logic [bdlc_pkg::NUM_W-1:0]    quotient
);

   logic [bdlc_pkg::DEN_W-1:0]     rem_ff;
   logic [bdlc_pkg::NUM_W-1:0]     quo_ff;
   logic [bdlc_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           run_ff;
   logic                           done_ff;
   logic [bdlc_pkg::DEN_W:0]       shift_in;
   logic                           fits_in;

   assign shift_in = {rem_ff, quo_ff[bdlc_pkg::NUM_W-1]};
   assign fits_in  = shift_in >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= bdlc_pkg::DIV_CNT_W'(bdlc_pkg::NUM_W);
            rem_ff <= '0;
            quo_ff <= dividend;
         end else if (run_ff) begin
            rem_ff <= fits_in ? bdlc_pkg::DEN_W'(shift_in - {1'b0, divisor})
                              : shift_in[bdlc_pkg::DEN_W-1:0];
            quo_ff <= {quo_ff[bdlc_pkg::NUM_W-2:0], fits_in};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == bdlc_pkg::DIV_CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/battery_dump_load_controller_unit.sv
// ----------------------------------------------------------------------------
// battery_dump_load_controller_unit
// averages adc sample pairs, calibrates them and runs the dump gate control
// ----------------------------------------------------------------------------
// sample request: when it closes a measurement, each channel runs a scale
//   multiply, a division on the 38 step shared divider and two multiply/add
//   steps; a zero average or a non positive current skips an add step
// control request: response registered in the cycle after acceptance
// one request at a time; req_stall is high while a measurement is computed
// synchronous active high reset clears control, sum and configuration registers
// ----------------------------------------------------------------------------
module battery_dump_load_controller_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bdlc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bdlc_pkg::rsp_type   rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_SCALE, S_DIV_GO, S_DIV_WAIT, S_SEG_MUL, S_SEG_ADD, S_FIN_MUL, S_FIN_ADD
   } state_type;

   // configuration registers
   logic [7:0]  num_samples_ff;
   logic [63:0] low_seg_ff, high_seg_ff, volt_cal_ff, curr_cal_ff;
   logic [22:0] dump_on_ff, dump_off_ff;

   // accumulation and measurement state
   logic [bdlc_pkg::SUM_W-1:0] vsum_ff, csum_ff;
   logic [7:0]                 count_ff;
   logic signed [31:0]         meas_v_ff, meas_c_ff;
   logic [1:0]                 status_ff;
   logic                       gate_ff;

   // sequencer and shared datapath
   state_type                  state_ff;
   logic                       chan_ff;     // 0 voltage, 1 current
   logic [bdlc_pkg::DEN_W-1:0] den_ff;
   logic signed [63:0]         prod_ff;
   logic signed [31:0]         val_ff;

   logic                       rsp_valid_ff;
   bdlc_pkg::rsp_type          rsp_ff;

   logic                       req_accept;
   logic                       rsp_free;

   // sample path
   logic [bdlc_pkg::SUM_W-1:0] vsum_in, csum_in;
   logic [7:0]                 count_in;
   logic [7:0]                 n_eff;
   logic                       meas_done;
   logic [bdlc_pkg::CNT_W-1:0] cnt_div;

   // shared multiplier
   logic signed [31:0]         mul_a, mul_b;
   logic signed [63:0]         prod_in;
   logic [63:0]                seg_cal, fin_cal;
   logic signed [31:0]         cal_res;

   // control step
   logic signed [32:0]         v_ext;
   logic [1:0]                 status_in;
   logic                       gate_in;
   logic                       green_in, red_in;

   logic                       div_done;
   logic [bdlc_pkg::NUM_W-1:0] div_quo;

   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !rsp_free;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = (state_ff == S_IDLE);

   // sample accumulation, a zero count setting acts as one
   assign vsum_in   = vsum_ff + bdlc_pkg::SUM_W'(req_data.voltage_code);
   assign csum_in   = csum_ff + bdlc_pkg::SUM_W'(req_data.current_code);
   assign count_in  = count_ff + 8'd1;
   assign n_eff     = (num_samples_ff == 8'd0) ? 8'd1 : num_samples_ff;
   assign meas_done = (count_in >= n_eff) || (count_in == 8'd0);
   assign cnt_div   = (count_in == 8'd0) ? bdlc_pkg::CNT_W'(256)
                                         : bdlc_pkg::CNT_W'(count_in);

   // segment choice follows the value that enters the correction
   assign seg_cal = (val_ff < bdlc_pkg::SPLIT_2V6_Q) ? low_seg_ff : high_seg_ff;
   assign fin_cal = chan_ff ? curr_cal_ff : volt_cal_ff;

   always_comb begin
      mul_a = val_ff;
      mul_b = $signed(fin_cal[63:32]);
      case (state_ff)
         S_SCALE: begin
            mul_a = $signed(32'(chan_ff ? csum_ff : vsum_ff));
            mul_b = $signed(32'(bdlc_pkg::SCALE_3V3_Q));
         end
         S_SEG_MUL: mul_b = $signed(seg_cal[63:32]);
         default:   mul_b = $signed(fin_cal[63:32]);
      endcase
   end

   assign prod_in = mul_a * mul_b;

   always_comb begin
      if (state_ff == S_SEG_ADD) begin
         cal_res = bdlc_pkg::cal_finish(prod_ff, $signed(seg_cal[31:0]));
      end else begin
         cal_res = bdlc_pkg::cal_finish(prod_ff, $signed(fin_cal[31:0]));
      end
   end

   // control step: manual release, override, then thresholds in priority
   assign v_ext = {meas_v_ff[31], meas_v_ff};

   always_comb begin
      status_in = status_ff;
      gate_in   = gate_ff;
      if (status_ff == bdlc_pkg::MODE_MANUAL && !req_data.override_switch) begin
         status_in = bdlc_pkg::MODE_AUTO_OFF;
         gate_in   = 1'b0;
      end
      if (req_data.override_switch) begin
         status_in = bdlc_pkg::MODE_MANUAL;
         gate_in   = 1'b0;
      end else if (v_ext > bdlc_pkg::HARD_HIGH_Q) begin
         status_in = bdlc_pkg::MODE_WARNING;
         gate_in   = 1'b1;
      end else if (v_ext > $signed({10'd0, dump_on_ff})) begin
         status_in = bdlc_pkg::MODE_AUTO_ON;
         gate_in   = 1'b1;
      end else if (v_ext < bdlc_pkg::HARD_LOW_Q) begin
         status_in = bdlc_pkg::MODE_WARNING;
         gate_in   = 1'b0;
      end else if (v_ext < $signed({10'd0, dump_off_ff})) begin
         status_in = bdlc_pkg::MODE_AUTO_OFF;
         gate_in   = 1'b0;
      end
   end

   // led drive by mode
   always_comb begin
      unique case (status_in)
         bdlc_pkg::MODE_AUTO_ON: begin
            green_in = 1'b0;
            red_in   = 1'b1;
         end
         bdlc_pkg::MODE_AUTO_OFF: begin
            green_in = 1'b1;
            red_in   = 1'b0;
         end
         bdlc_pkg::MODE_MANUAL: begin
            green_in = req_data.blink_on;
            red_in   = 1'b0;
         end
         default: begin
            green_in = req_data.blink_on;
            red_in   = req_data.blink_on;
         end
      endcase
   end

   // configuration writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         num_samples_ff <= bdlc_pkg::NUM_SAMPLES_RESET;
         low_seg_ff     <= bdlc_pkg::CAL_RESET;
         high_seg_ff    <= bdlc_pkg::CAL_RESET;
         volt_cal_ff    <= bdlc_pkg::CAL_RESET;
         curr_cal_ff    <= bdlc_pkg::CAL_RESET;
         dump_on_ff     <= bdlc_pkg::DUMP_ON_RESET;
         dump_off_ff    <= bdlc_pkg::DUMP_OFF_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bdlc_pkg::CSR_NUM_SAMPLES: num_samples_ff <= csr_wdata[7:0];
            bdlc_pkg::CSR_LOW_SEG:     low_seg_ff     <= csr_wdata;
            bdlc_pkg::CSR_HIGH_SEG:    high_seg_ff    <= csr_wdata;
            bdlc_pkg::CSR_VOLT_CAL:    volt_cal_ff    <= csr_wdata;
            bdlc_pkg::CSR_CURR_CAL:    curr_cal_ff    <= csr_wdata;
            bdlc_pkg::CSR_DUMP_ON:     dump_on_ff     <= csr_wdata[22:0];
            bdlc_pkg::CSR_DUMP_OFF:    dump_off_ff    <= csr_wdata[22:0];
            default: ;
         endcase
      end
   end

   // sequencer, measurement state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chan_ff      <= 1'b0;
         vsum_ff      <= '0;
         csum_ff      <= '0;
         count_ff     <= '0;
         meas_v_ff    <= '0;
         meas_c_ff    <= '0;
         status_ff    <= bdlc_pkg::MODE_AUTO_OFF;
         gate_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response loads on a control request, drops once taken
         if (state_ff == S_IDLE && req_accept && req_data.cmd) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept && !req_data.cmd) begin
                  vsum_ff  <= vsum_in;
                  csum_ff  <= csum_in;
                  count_ff <= count_in;
                  if (meas_done) begin
                     // divisor is cnt * 4095
                     den_ff   <= {cnt_div, {bdlc_pkg::ADC_BITS{1'b0}}}
                                 - bdlc_pkg::DEN_W'(cnt_div);
                     chan_ff  <= 1'b0;
                     state_ff <= S_SCALE;
                  end
               end else if (req_accept) begin
                  status_ff    <= status_in;
                  gate_ff      <= gate_in;
                  rsp_ff.gate        <= gate_in;
                  rsp_ff.green_drive <= green_in;
                  rsp_ff.red_led     <= red_in;
                  rsp_ff.mode        <= status_in;
                  rsp_ff.voltage_out <= meas_v_ff;
                  rsp_ff.current_out <= meas_c_ff;
               end
            end
            S_SCALE: begin
               prod_ff  <= prod_in;
               state_ff <= S_DIV_GO;
            end
            S_DIV_GO: state_ff <= S_DIV_WAIT;
            S_DIV_WAIT: begin
               if (div_done) begin
                  val_ff   <= $signed(div_quo[31:0]);
                  state_ff <= S_SEG_MUL;
               end
            end
            S_SEG_MUL: begin
               prod_ff <= prod_in;
               // a zero average skips the segment correction
               if (val_ff == 32'sd0) begin
                  state_ff <= S_FIN_MUL;
               end else begin
                  state_ff <= S_SEG_ADD;
               end
            end
            S_SEG_ADD: begin
               val_ff   <= cal_res;
               state_ff <= S_FIN_MUL;
            end
            S_FIN_MUL: begin
               prod_ff <= prod_in;
               // current not positive reads as zero
               if (chan_ff && val_ff <= 32'sd0) begin
                  meas_c_ff <= '0;
                  vsum_ff   <= '0;
                  csum_ff   <= '0;
                  count_ff  <= '0;
                  state_ff  <= S_IDLE;
               end else begin
                  state_ff <= S_FIN_ADD;
               end
            end
            S_FIN_ADD: begin
               if (!chan_ff) begin
                  meas_v_ff <= cal_res;
                  chan_ff   <= 1'b1;
                  state_ff  <= S_SCALE;
               end else begin
                  meas_c_ff <= cal_res;
                  vsum_ff   <= '0;
                  csum_ff   <= '0;
                  count_ff  <= '0;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   bdlc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIV_GO),
      .dividend (prod_ff[bdlc_pkg::NUM_W-1:0]),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/bdlc_checker.sv
// ----------------------------------------------------------------------------
// bdlc_checker
// port level checks of the dump load controller
// ----------------------------------------------------------------------------
module bdlc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input bdlc_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bdlc_pkg::rsp_type rsp_data
);

   // a stalled request stays with its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // gate drive only in auto on or warning
   a_gate_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.gate |->
         (rsp_data.mode == bdlc_pkg::MODE_AUTO_ON || rsp_data.mode == bdlc_pkg::MODE_WARNING))
      else $error("gate on in an off mode");

   a_manual: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mode == bdlc_pkg::MODE_MANUAL |->
         !rsp_data.gate && !rsp_data.red_led)
      else $error("manual mode drives gate or red");

   a_auto_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.mode == bdlc_pkg::MODE_AUTO_ON |->
         rsp_data.gate && rsp_data.red_led && !rsp_data.green_drive)
      else $error("auto on outputs wrong");

endmodule

bind battery_dump_load_controller_unit bdlc_checker u_bdlc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
